// ===== rtl/v3a_pkg.sv =====
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared types, constants and helpers for the 3D vector arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int W1        = W + 1;
	localparam int PW        = 2 * W;
	localparam int SUMW      = PW + 2;
	localparam int SQ_STEPS  = W;
	localparam int QBITS     = FRAC_BITS + 1;
	localparam int DW        = W + FRAC_BITS;
	localparam int MODE_W    = 4;
	localparam int TOL_W     = W - 1;

	localparam logic [W-1:0]     WORD_MAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]     WORD_MIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD    = 4'd0,
		MODE_SUB    = 4'd1,
		MODE_SCALE  = 4'd2,
		MODE_DOT    = 4'd3,
		MODE_CROSS  = 4'd4,
		MODE_NORMSQ = 4'd5,
		MODE_NORM   = 4'd6,
		MODE_UNIT   = 4'd7,
		MODE_NEGATE = 4'd8,
		MODE_EQUAL  = 4'd9
	} mode_t;

	// results settled before the root, plus what the unit vector still needs
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [W-1:0]      r_x;
		logic [W-1:0]      r_y;
		logic [W-1:0]      r_z;
		logic [W-1:0]      sc;
		logic              eq;
		logic              ovf;
		logic [W-1:0]      mag_x;
		logic [W-1:0]      mag_y;
		logic [W-1:0]      mag_z;
		logic              neg_x;
		logic              neg_y;
		logic              neg_z;
	} side_t;

	// {overflow, saturated word}
	function automatic logic [W:0] sat_w(input logic signed [SUMW-1:0] v);
		logic [SUMW-W:0] hi;
		hi = v[SUMW-1:W-1];
		if ((&hi) || ~(|hi)) begin
			sat_w = {1'b0, v[W-1:0]};
		end else if (v[SUMW-1]) begin
			sat_w = {1'b1, WORD_MIN};
		end else begin
			sat_w = {1'b1, WORD_MAX};
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/v3a_front.sv =====
// ----------------------------------------------------------------------------
// v3a_front
// Three stages: products, sums, shift and saturate. Builds the radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [v3a_pkg::MODE_W-1:0]   mode,
	input  wire logic signed [v3a_pkg::W-1:0] a_x,
	input  wire logic signed [v3a_pkg::W-1:0] a_y,
	input  wire logic signed [v3a_pkg::W-1:0] a_z,
	input  wire logic signed [v3a_pkg::W-1:0] b_x,
	input  wire logic signed [v3a_pkg::W-1:0] b_y,
	input  wire logic signed [v3a_pkg::W-1:0] b_z,
	input  wire logic signed [v3a_pkg::W-1:0] scale_factor,
	input  wire logic [v3a_pkg::TOL_W-1:0]    tol,
	output logic                              out_valid,
	output v3a_pkg::side_t                    out_side,
	output logic [v3a_pkg::PW-1:0]            out_rad
);
	import v3a_pkg::*;

	logic signed [W-1:0]  av [3];
	logic signed [W-1:0]  bv [3];
	logic signed [W-1:0]  ml [3];
	logic signed [W-1:0]  mr [3];
	logic signed [W-1:0]  cl [3];
	logic signed [W-1:0]  cr [3];
	logic [W-1:0]         simp [3];
	logic                 simp_ovf;
	logic                 eq_c;

	logic                 v_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic signed [PW-1:0] p_s1 [3];
	logic signed [PW-1:0] pc_s1 [3];
	logic [W-1:0]         simp_s1 [3];
	logic                 sovf_s1;
	logic                 eq_s1;
	logic [W-1:0]         mag_s1 [3];
	logic                 neg_s1 [3];

	logic                   v_s2;
	logic [MODE_W-1:0]      mode_s2;
	logic signed [PW-1:0]   p_s2 [3];
	logic signed [PW:0]     dif_s2 [3];
	logic signed [SUMW-1:0] sum_s2;
	logic [W-1:0]           simp_s2 [3];
	logic                   sovf_s2;
	logic                   eq_s2;
	logic [W-1:0]           mag_s2 [3];
	logic                   neg_s2 [3];

	logic                 v_s3;
	side_t                side_s3;
	logic [PW-1:0]        rad_s3;
	side_t                side_c;

	assign av[0] = a_x;
	assign av[1] = a_y;
	assign av[2] = a_z;
	assign bv[0] = b_x;
	assign bv[1] = b_y;
	assign bv[2] = b_z;

	// cross: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
	assign cl[0] = a_z;
	assign cr[0] = b_y;
	assign cl[1] = a_x;
	assign cr[1] = b_z;
	assign cl[2] = a_y;
	assign cr[2] = b_x;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ml[i] = av[i];
			mr[i] = av[i];
		end
		case (mode)
			MODE_SCALE: begin
				for (int i = 0; i < 3; i++) mr[i] = scale_factor;
			end
			MODE_DOT: begin
				for (int i = 0; i < 3; i++) mr[i] = bv[i];
			end
			MODE_CROSS: begin
				ml[0] = a_y; mr[0] = b_z;
				ml[1] = a_z; mr[1] = b_x;
				ml[2] = a_x; mr[2] = b_y;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		logic signed [W1-1:0] s;
		logic signed [W1-1:0] d;
		logic [W1-1:0]        ad;
		logic [W:0]           sr;
		simp_ovf = 1'b0;
		eq_c     = 1'b1;
		for (int i = 0; i < 3; i++) begin
			case (mode)
				MODE_ADD:    s = W1'(av[i]) + W1'(bv[i]);
				MODE_SUB:    s = W1'(av[i]) - W1'(bv[i]);
				MODE_NEGATE: s = -W1'(av[i]);
				default:     s = '0;
			endcase
			sr       = sat_w(SUMW'(s));
			simp[i]  = sr[W-1:0];
			simp_ovf = simp_ovf | sr[W];
			d        = W1'(bv[i]) - W1'(av[i]);
			ad       = d[W] ? W1'(-d) : W1'(d);
			if (!(ad < {2'b00, tol})) eq_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			sovf_s1 <= simp_ovf;
			eq_s1   <= eq_c;
			for (int i = 0; i < 3; i++) begin
				p_s1[i]    <= PW'(ml[i]) * PW'(mr[i]);
				pc_s1[i]   <= PW'(cl[i]) * PW'(cr[i]);
				simp_s1[i] <= simp[i];
				neg_s1[i]  <= av[i][W-1];
				mag_s1[i]  <= av[i][W-1] ? W'(-av[i]) : W'(av[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			sovf_s2 <= sovf_s1;
			eq_s2   <= eq_s1;
			sum_s2  <= SUMW'(p_s1[0]) + SUMW'(p_s1[1]) + SUMW'(p_s1[2]);
			for (int i = 0; i < 3; i++) begin
				p_s2[i]    <= p_s1[i];
				dif_s2[i]  <= (PW+1)'(p_s1[i]) - (PW+1)'(pc_s1[i]);
				simp_s2[i] <= simp_s1[i];
				mag_s2[i]  <= mag_s1[i];
				neg_s2[i]  <= neg_s1[i];
			end
		end
	end

	always_comb begin
		logic signed [SUMW-1:0] t;
		logic [W:0]             sr [3];
		logic [W:0]             ss;
		side_c       = '0;
		side_c.mode  = mode_s2;
		side_c.mag_x = mag_s2[0];
		side_c.mag_y = mag_s2[1];
		side_c.mag_z = mag_s2[2];
		side_c.neg_x = neg_s2[0];
		side_c.neg_y = neg_s2[1];
		side_c.neg_z = neg_s2[2];
		t  = sum_s2 >>> FRAC_BITS;
		ss = sat_w(t);
		for (int i = 0; i < 3; i++) begin
			if (mode_s2 == MODE_SCALE) begin
				t = SUMW'(p_s2[i]) >>> FRAC_BITS;
			end else begin
				t = SUMW'(dif_s2[i]) >>> FRAC_BITS;
			end
			sr[i] = sat_w(t);
		end
		case (mode_s2)
			MODE_ADD, MODE_SUB, MODE_NEGATE: begin
				side_c.r_x = simp_s2[0];
				side_c.r_y = simp_s2[1];
				side_c.r_z = simp_s2[2];
				side_c.ovf = sovf_s2;
			end
			MODE_SCALE, MODE_CROSS: begin
				side_c.r_x = sr[0][W-1:0];
				side_c.r_y = sr[1][W-1:0];
				side_c.r_z = sr[2][W-1:0];
				side_c.ovf = sr[0][W] | sr[1][W] | sr[2][W];
			end
			MODE_DOT, MODE_NORMSQ: begin
				side_c.sc  = ss[W-1:0];
				side_c.ovf = ss[W];
			end
			MODE_EQUAL: begin
				side_c.eq = eq_s2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c;
			rad_s3  <= sum_s2[PW-1:0];
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign out_rad   = rad_s3;

endmodule

`default_nettype wire

// ===== rtl/v3a_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire v3a_pkg::side_t           in_side,
	input  wire logic [v3a_pkg::PW-1:0]   in_rad,
	output logic                          out_valid,
	output v3a_pkg::side_t                out_side,
	output logic [v3a_pkg::W-1:0]         out_root
);
	import v3a_pkg::*;

	localparam int RW = W + 3;

	logic          v_s    [SQ_STEPS];
	side_t         side_s [SQ_STEPS];
	logic [RW-1:0] rem_s  [SQ_STEPS];
	logic [W-1:0]  root_s [SQ_STEPS];
	logic [PW-1:0] rad_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic          pv;
		side_t         pside;
		logic [RW-1:0] prem;
		logic [W-1:0]  proot;
		logic [PW-1:0] prad;
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = in_rad;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pside = side_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign prad  = rad_s[k-1];
		end

		assign cur   = {prem[RW-3:0], prad[PW-1:PW-2]};
		assign trial = {1'b0, proot, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= pside;
				rem_s[k]  <= ge ? cur - trial : cur;
				root_s[k] <= {proot[W-2:0], ge};
				rad_s[k]  <= {prad[PW-3:0], 2'b00};
			end
		end
	end

	assign out_valid = v_s[SQ_STEPS-1];
	assign out_side  = side_s[SQ_STEPS-1];
	assign out_root  = root_s[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/v3a_div.sv =====
// ----------------------------------------------------------------------------
// v3a_div
// Three-lane pipelined restoring divider for the unit vector, one quotient
// bit per stage: |a_i| * 2^FRAC_BITS / norm.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire v3a_pkg::side_t           in_side,
	input  wire logic [v3a_pkg::W-1:0]    in_root,
	output logic                          out_valid,
	output v3a_pkg::side_t                out_side,
	output logic [v3a_pkg::W-1:0]         out_root,
	output logic [v3a_pkg::QBITS-1:0]     out_q_x,
	output logic [v3a_pkg::QBITS-1:0]     out_q_y,
	output logic [v3a_pkg::QBITS-1:0]     out_q_z
);
	import v3a_pkg::*;

	logic             v_s    [QBITS];
	side_t            side_s [QBITS];
	logic [W-1:0]     nr_s   [QBITS];
	logic [W:0]       rem_s  [QBITS][3];
	logic [QBITS-1:0] lo_s   [QBITS][3];
	logic [QBITS-1:0] q_s    [QBITS][3];

	logic [W-1:0]     mag_in [3];
	logic [W:0]       rem0   [3];
	logic [QBITS-1:0] lo0    [3];

	assign mag_in[0] = in_side.mag_x;
	assign mag_in[1] = in_side.mag_y;
	assign mag_in[2] = in_side.mag_z;

	always_comb begin
		logic [DW-1:0] dvd;
		for (int l = 0; l < 3; l++) begin
			dvd     = {mag_in[l], {FRAC_BITS{1'b0}}};
			rem0[l] = (W+1)'(dvd[DW-1:QBITS]);
			lo0[l]  = dvd[QBITS-1:0];
		end
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_step
		logic             pv;
		side_t            pside;
		logic [W-1:0]     pnr;
		logic [W:0]       prem [3];
		logic [QBITS-1:0] plo  [3];
		logic [QBITS-1:0] pq   [3];

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign pside = in_side;
			assign pnr   = in_root;
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign prem[l] = rem0[l];
				assign plo[l]  = lo0[l];
				assign pq[l]   = '0;
			end
		end else begin : g_next
			assign pv    = v_s[j-1];
			assign pside = side_s[j-1];
			assign pnr   = nr_s[j-1];
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign prem[l] = rem_s[j-1][l];
				assign plo[l]  = lo_s[j-1][l];
				assign pq[l]   = q_s[j-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			logic [W:0] cur;
			logic       ge;
			if (en) begin
				side_s[j] <= pside;
				nr_s[j]   <= pnr;
				for (int l = 0; l < 3; l++) begin
					cur           = {prem[l][W-1:0], plo[l][QBITS-1]};
					ge            = cur >= {1'b0, pnr};
					rem_s[j][l]   <= ge ? cur - {1'b0, pnr} : cur;
					lo_s[j][l]    <= {plo[l][QBITS-2:0], 1'b0};
					q_s[j][l]     <= {pq[l][QBITS-2:0], ge};
				end
			end
		end
	end

	assign out_valid = v_s[QBITS-1];
	assign out_side  = side_s[QBITS-1];
	assign out_root  = nr_s[QBITS-1];
	assign out_q_x   = q_s[QBITS-1][0];
	assign out_q_y   = q_s[QBITS-1][1];
	assign out_q_z   = q_s[QBITS-1][2];

endmodule

`default_nettype wire

// ===== rtl/vector3_alu_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_alu_unit
// Q16.16 3D vector unit: add, sub, scale, dot, cross, norms, unit, negate,
// tolerance compare, with saturation.
// ----------------------------------------------------------------------------
// Every mode takes the same path from input transaction to result.
// Throughput: one transaction per cycle; a stall on the result side holds
// the whole pipeline (3 arithmetic stages, 32 root stages, 17 divide stages,
// output register).
// Reset: clears all valid bits; the equality tolerance (tol_q) returns to 1.
`default_nettype none

module vector3_alu_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
	input  wire logic [7*v3a_pkg::W-1:0]       s_tdata,
	// mode
	input  wire logic [v3a_pkg::MODE_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// r_x, r_y, r_z, scalar_out, is_equal, overflowed, zero_length, zero pad
	output logic [4*v3a_pkg::W+7:0]            m_tdata,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [v3a_pkg::TOL_W-1:0]     cfg_data
);
	import v3a_pkg::*;

	logic              en;
	logic [TOL_W-1:0]  tol_q;

	logic              f_valid;
	side_t             f_side;
	logic [PW-1:0]     f_rad;
	logic              q_valid;
	side_t             q_side;
	logic [W-1:0]      q_root;
	logic              d_valid;
	side_t             d_side;
	logic [W-1:0]      d_root;
	logic [QBITS-1:0]  d_q [3];

	logic [W-1:0]      fin_r [3];
	logic [W-1:0]      fin_sc;
	logic              fin_eq;
	logic              fin_ovf;
	logic              fin_zl;

	logic              out_valid_q;
	logic [W-1:0]      rx_q;
	logic [W-1:0]      ry_q;
	logic [W-1:0]      rz_q;
	logic [W-1:0]      sc_q;
	logic              eq_q;
	logic              ovf_q;
	logic              zl_q;

	assign en        = ~out_valid_q | m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	v3a_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.mode         (s_tuser),
		.a_x          (s_tdata[W-1:0]),
		.a_y          (s_tdata[2*W-1:W]),
		.a_z          (s_tdata[3*W-1:2*W]),
		.b_x          (s_tdata[4*W-1:3*W]),
		.b_y          (s_tdata[5*W-1:4*W]),
		.b_z          (s_tdata[6*W-1:5*W]),
		.scale_factor (s_tdata[7*W-1:6*W]),
		.tol          (tol_q),
		.out_valid    (f_valid),
		.out_side     (f_side),
		.out_rad      (f_rad)
	);

	v3a_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_side   (f_side),
		.in_rad    (f_rad),
		.out_valid (q_valid),
		.out_side  (q_side),
		.out_root  (q_root)
	);

	v3a_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.in_side   (q_side),
		.in_root   (q_root),
		.out_valid (d_valid),
		.out_side  (d_side),
		.out_root  (d_root),
		.out_q_x   (d_q[0]),
		.out_q_y   (d_q[1]),
		.out_q_z   (d_q[2])
	);

	always_comb begin
		logic               negs [3];
		logic signed [W1-1:0] qv;
		logic [W:0]         sr;
		negs[0] = d_side.neg_x;
		negs[1] = d_side.neg_y;
		negs[2] = d_side.neg_z;
		fin_r[0] = d_side.r_x;
		fin_r[1] = d_side.r_y;
		fin_r[2] = d_side.r_z;
		fin_sc   = d_side.sc;
		fin_eq   = d_side.eq;
		fin_ovf  = d_side.ovf;
		fin_zl   = 1'b0;
		case (d_side.mode)
			MODE_NORM: begin
				sr      = sat_w(SUMW'($signed({1'b0, d_root})));
				fin_sc  = sr[W-1:0];
				fin_ovf = sr[W];
			end
			MODE_UNIT: begin
				if (d_root == '0) begin
					fin_zl = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						qv       = W1'($signed({1'b0, d_q[i]}));
						if (negs[i]) qv = -qv;
						sr       = sat_w(SUMW'(qv));
						fin_r[i] = sr[W-1:0];
						fin_ovf  = fin_ovf | sr[W];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_q  <= fin_r[0];
			ry_q  <= fin_r[1];
			rz_q  <= fin_r[2];
			sc_q  <= fin_sc;
			eq_q  <= fin_eq;
			ovf_q <= fin_ovf;
			zl_q  <= fin_zl;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, zl_q, ovf_q, eq_q, sc_q, rz_q, ry_q, rx_q};

	a_zero_len_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zl_q |-> rx_q == '0 && ry_q == '0 && rz_q == '0 && sc_q == '0)
		else $error("zero length result carries data");

	a_eq_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(eq_q && ovf_q))
		else $error("equality and overflow together");

	a_zl_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(zl_q && ovf_q))
		else $error("zero length and overflow together");

	a_eq_no_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && eq_q |-> rx_q == '0 && ry_q == '0 && rz_q == '0 && sc_q == '0)
		else $error("equality result carries data");

endmodule

`default_nettype wire
